FILE: sv/wcsd_pkg.sv
// Shared types and constants for the weighted cache slot directory.
package wcsd_pkg;

  localparam int TAG_W    = 32;
  localparam int TIME_W   = 32;
  localparam int HITS_W   = 16;
  localparam int HW_W     = 10;
  localparam int OP_W     = 2;
  localparam int SIDX_W   = 6;
  localparam int GAIN_W   = HITS_W + HW_W;
  localparam int AGE_W    = TIME_W + 1;
  localparam int WEIGHT_W = AGE_W + 2;

  localparam logic [OP_W-1:0]   OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0]   OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0]   OP_HIT    = 2'd2;

  localparam logic [HITS_W-1:0] HITS_MAX       = 16'hFFFF;
  localparam logic [HW_W-1:0]   HIT_WEIGHT_RST = 10'd10;

  // One slot of the directory store.
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] stamp;
    logic [HITS_W-1:0] hits;
  } entry_t;

  // What the weight unit reports about one scanned slot.
  typedef struct packed {
    logic                     vld;
    logic                     empty;
    logic                     match;
    logic [GAIN_W-1:0]        gain;
    logic signed [AGE_W-1:0]  age;
  } score_t;

endpackage

FILE: sv/wcsd_if.sv
// Valid/ready channel interfaces for the input and result words.
interface wcsd_in_if;
  logic                        valid;
  logic                        ready;
  logic [wcsd_pkg::OP_W-1:0]   opcode;
  logic [wcsd_pkg::TAG_W-1:0]  tag;
  logic [wcsd_pkg::TIME_W-1:0] now;
  logic [wcsd_pkg::SIDX_W-1:0] slot_index;

  modport source (output valid, opcode, tag, now, slot_index, input ready);
  modport sink   (input valid, opcode, tag, now, slot_index, output ready);
endinterface

interface wcsd_out_if;
  logic                        valid;
  logic                        ready;
  logic [wcsd_pkg::SIDX_W-1:0] slot;
  logic                        found;
  logic                        evicted;

  modport source (output valid, slot, found, evicted, input ready);
  modport sink   (input valid, slot, found, evicted, output ready);
endinterface

FILE: sv/wcsd_weight_unit.sv
// Shared scoring stage: tag compare, hit gain product and signed age of one slot.
module wcsd_weight_unit #(
  parameter int IDX_W = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_vld,
  input  logic [IDX_W-1:0]            rd_idx,
  input  wcsd_pkg::entry_t            entry,
  input  logic                        entry_valid,
  input  logic [wcsd_pkg::TAG_W-1:0]  tag,
  input  logic [wcsd_pkg::TIME_W-1:0] now,
  input  logic [wcsd_pkg::HW_W-1:0]   hit_weight,
  output wcsd_pkg::score_t            score,
  output logic [IDX_W-1:0]            score_idx
);

  wcsd_pkg::score_t score_r;
  wcsd_pkg::score_t score_nxt;
  logic [IDX_W-1:0] idx_r;

  always_comb begin
    score_nxt.vld   = rd_vld;
    score_nxt.empty = !entry_valid;
    score_nxt.match = (entry.tag == tag);
    score_nxt.gain  = wcsd_pkg::GAIN_W'(entry.hits) * wcsd_pkg::GAIN_W'(hit_weight);
    // Exact signed difference: a stamp in the future gives a negative age.
    score_nxt.age   = $signed({1'b0, now}) - $signed({1'b0, entry.stamp});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_r.vld <= 1'b0;
    end else begin
      score_r.vld <= score_nxt.vld;
    end
    score_r.empty <= score_nxt.empty;
    score_r.match <= score_nxt.match;
    score_r.gain  <= score_nxt.gain;
    score_r.age   <= score_nxt.age;
    idx_r         <= rd_idx;
  end

  assign score     = score_r;
  assign score_idx = idx_r;

endmodule

FILE: sv/weighted_cache_slot_directory.sv
// Weighted cache slot directory: sequencer, slot store and result register.
// Lookup and insert scan the slots in order through the one read port and stop at the first
// empty or matching slot or after the last; record hit updates one slot; an unused opcode goes
// straight to a result with nothing found. One word is in work at a time and the next is taken
// as its result is offered.
// A synchronous reset clears the valid bits, sequencer and result valid and sets hit_weight to 10.
module weighted_cache_slot_directory #(
  parameter int NUM_SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  wcsd_in_if.sink                       in_chan,
  wcsd_out_if.source                    out_chan,
  input  logic                          cfg_we,
  input  logic [wcsd_pkg::HW_W-1:0]     cfg_wdata
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_SCAN    = 6'b000010,
    ST_WRITE   = 6'b000100,
    ST_HIT_RD  = 6'b001000,
    ST_HIT_UPD = 6'b010000,
    ST_FIN     = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration register.
  logic [wcsd_pkg::HW_W-1:0] hw_r;

  // Captured input word.
  logic [wcsd_pkg::OP_W-1:0]   op_r, op_nxt;
  logic [wcsd_pkg::TAG_W-1:0]  tag_r, tag_nxt;
  logic [wcsd_pkg::TIME_W-1:0] now_r, now_nxt;
  logic [wcsd_pkg::SIDX_W-1:0] sidx_r, sidx_nxt;

  // Scan bookkeeping.
  logic [CNT_W-1:0]                        cnt_r, cnt_nxt;
  logic signed [wcsd_pkg::WEIGHT_W-1:0]    least_r, least_nxt;
  logic [IDX_W-1:0]                        chosen_r, chosen_nxt;
  logic                                    found_r, found_nxt;
  logic                                    evict_r, evict_nxt;

  // Slot store: valid bits in flops, tag/stamp/hits in a memory.
  logic [NUM_SLOTS-1:0] valid_r;
  wcsd_pkg::entry_t     mem [NUM_SLOTS];
  wcsd_pkg::entry_t     mem_q;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic                 mem_we;
  logic [IDX_W-1:0]     wr_addr;
  wcsd_pkg::entry_t     wr_data;
  logic                 valid_set;

  // First scan stage: the read issued last cycle.
  logic             s1_vld_r;
  logic [IDX_W-1:0] s1_idx_r;

  wcsd_pkg::score_t score;
  logic [IDX_W-1:0] score_idx;

  // Result register.
  logic                        out_valid_r, out_valid_nxt;
  logic [wcsd_pkg::SIDX_W-1:0] out_slot_r, out_slot_nxt;
  logic                        out_found_r, out_found_nxt;
  logic                        out_evict_r, out_evict_nxt;

  logic                                 scan_rd;
  logic                                 sidx_ok;
  logic [IDX_W-1:0]                     sidx_idx;
  logic signed [wcsd_pkg::WEIGHT_W-1:0] weight;
  logic                                 fin_load;
  logic [wcsd_pkg::HITS_W-1:0]          hits_inc;

  assign in_chan.ready = (state_r == ST_IDLE);

  assign scan_rd  = (state_r == ST_SCAN) && (cnt_r < CNT_W'(NUM_SLOTS));
  assign sidx_ok  = (32'(sidx_r) < NUM_SLOTS);
  assign sidx_idx = IDX_W'(sidx_r);

  // Weight of the scored slot: hits times hit_weight minus age, exact in 35 bits.
  assign weight = wcsd_pkg::WEIGHT_W'($signed({1'b0, score.gain}))
                - wcsd_pkg::WEIGHT_W'(score.age);

  assign hits_inc = (mem_q.hits == wcsd_pkg::HITS_MAX) ? mem_q.hits
                                                       : mem_q.hits + 1'b1;

  assign fin_load = (state_r == ST_FIN) && (!out_valid_r || out_chan.ready);

  wcsd_weight_unit #(
    .IDX_W (IDX_W)
  ) u_weight (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_vld      (s1_vld_r),
    .rd_idx      (s1_idx_r),
    .entry       (mem_q),
    .entry_valid (valid_r[s1_idx_r]),
    .tag         (tag_r),
    .now         (now_r),
    .hit_weight  (hw_r),
    .score       (score),
    .score_idx   (score_idx)
  );

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    tag_nxt    = tag_r;
    now_nxt    = now_r;
    sidx_nxt   = sidx_r;
    cnt_nxt    = cnt_r;
    least_nxt  = least_r;
    chosen_nxt = chosen_r;
    found_nxt  = found_r;
    evict_nxt  = evict_r;
    rd_en      = 1'b0;
    rd_addr    = cnt_r[IDX_W-1:0];
    mem_we     = 1'b0;
    wr_addr    = chosen_r;
    wr_data    = '{tag: tag_r, stamp: now_r, hits: '0};
    valid_set  = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          op_nxt     = in_chan.opcode;
          tag_nxt    = in_chan.tag;
          now_nxt    = in_chan.now;
          sidx_nxt   = in_chan.slot_index;
          cnt_nxt    = '0;
          least_nxt  = '0;
          chosen_nxt = '0;
          found_nxt  = 1'b0;
          evict_nxt  = 1'b0;
          case (in_chan.opcode)
            wcsd_pkg::OP_LOOKUP: state_nxt = ST_SCAN;
            wcsd_pkg::OP_INSERT: state_nxt = ST_SCAN;
            wcsd_pkg::OP_HIT:    state_nxt = ST_HIT_RD;
            default:             state_nxt = ST_FIN;
          endcase
        end
      end

      ST_SCAN: begin
        // Reads go out one slot per cycle; scores return via the read and score registers.
        rd_en = scan_rd;
        if (scan_rd) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (score.vld) begin
          if (score.empty || score.match) begin
            // First empty or matching slot ends the scan.
            if (op_r == wcsd_pkg::OP_LOOKUP && score.empty) begin
              chosen_nxt = '0;
            end else begin
              chosen_nxt = score_idx;
            end
            found_nxt = !score.empty && score.match;
            state_nxt = (op_r == wcsd_pkg::OP_INSERT) ? ST_WRITE : ST_FIN;
          end else begin
            if (op_r == wcsd_pkg::OP_INSERT && weight < least_r) begin
              least_nxt  = weight;
              chosen_nxt = score_idx;
            end
            if (score_idx == IDX_W'(NUM_SLOTS - 1)) begin
              evict_nxt = (op_r == wcsd_pkg::OP_INSERT);
              state_nxt = (op_r == wcsd_pkg::OP_INSERT) ? ST_WRITE : ST_FIN;
            end
          end
        end
      end

      ST_WRITE: begin
        mem_we    = 1'b1;
        valid_set = 1'b1;
        state_nxt = ST_FIN;
      end

      ST_HIT_RD: begin
        if (sidx_ok && valid_r[sidx_idx]) begin
          rd_en     = 1'b1;
          rd_addr   = sidx_idx;
          state_nxt = ST_HIT_UPD;
        end else begin
          state_nxt = ST_FIN;
        end
      end

      ST_HIT_UPD: begin
        mem_we    = 1'b1;
        wr_addr   = sidx_idx;
        wr_data   = '{tag: mem_q.tag, stamp: now_r, hits: hits_inc};
        found_nxt = 1'b1;
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        if (fin_load) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result register: loads in the final state, drains on the far side's ready.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_slot_nxt  = out_slot_r;
    out_found_nxt = out_found_r;
    out_evict_nxt = out_evict_r;
    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fin_load) begin
      out_valid_nxt = 1'b1;
      out_slot_nxt  = (op_r == wcsd_pkg::OP_HIT) ? sidx_r : wcsd_pkg::SIDX_W'(chosen_r);
      out_found_nxt = found_r;
      out_evict_nxt = evict_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hw_r        <= wcsd_pkg::HIT_WEIGHT_RST;
      valid_r     <= '0;
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        hw_r <= cfg_wdata;
      end
      if (valid_set) begin
        valid_r[chosen_r] <= 1'b1;
      end
      s1_vld_r    <= scan_rd;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    tag_r       <= tag_nxt;
    now_r       <= now_nxt;
    sidx_r      <= sidx_nxt;
    cnt_r       <= cnt_nxt;
    least_r     <= least_nxt;
    chosen_r    <= chosen_nxt;
    found_r     <= found_nxt;
    evict_r     <= evict_nxt;
    s1_idx_r    <= rd_addr;
    out_slot_r  <= out_slot_nxt;
    out_found_r <= out_found_nxt;
    out_evict_r <= out_evict_nxt;
  end

  // Slot store with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.slot    = out_slot_r;
  assign out_chan.found   = out_found_r;
  assign out_chan.evicted = out_evict_r;

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state is not one-hot");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result word appeared outside the final state");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_WRITE || state_r == ST_HIT_UPD))
    else $error("slot store written outside an update state");

  a_insert_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |=> valid_r[chosen_r])
    else $error("inserted slot not marked valid");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (cnt_r <= CNT_W'(NUM_SLOTS)))
    else $error("scan counter ran past the directory");
`endif

endmodule

FILE: tb/wcsd_checker.sv
// Result checker for the weighted cache slot directory: tracks the slots and compares results.
module wcsd_checker import wcsd_pkg::*; #(
  parameter int NUM_SLOTS = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  wcsd_in_if              in_mon,
  wcsd_out_if             out_mon,
  input  logic            cfg_we,
  input  logic [HW_W-1:0] cfg_wdata,
  output int              fail_count,
  output int              pending_count,
  output int              result_count,
  output int              evict_count,
  output int              lookup_hit_count,
  output int              saturated_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SIDX_W-1:0] slot;
    logic              found;
    logic              evicted;
  } dir_result_t;

  // Shadow copy of the directory and its one register.
  logic              slot_live  [NUM_SLOTS];
  logic [TAG_W-1:0]  slot_tag   [NUM_SLOTS];
  logic [TIME_W-1:0] slot_stamp [NUM_SLOTS];
  logic [HITS_W-1:0] slot_hits  [NUM_SLOTS];
  logic [HW_W-1:0]   weight_per_hit;

  dir_result_t expected_q[$];

  int fails      = 0;
  int results    = 0;
  int evictions  = 0;
  int lookup_hits = 0;
  int saturated  = 0;

  assign fail_count       = fails;
  assign result_count     = results;
  assign evict_count      = evictions;
  assign lookup_hit_count = lookup_hits;
  assign saturated_count  = saturated;

  task automatic report(input string what);
    fails++;
    if (fails <= 40) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Retention score of a slot: recorded hits count for it, age counts against it.
  function automatic longint retention_score(input int idx, input logic [TIME_W-1:0] now);
    longint gain;
    longint age;
    gain = longint'(slot_hits[idx]) * longint'(weight_per_hit);
    age  = longint'({32'd0, now}) - longint'({32'd0, slot_stamp[idx]});
    return gain - age;
  endfunction

  // Applies one accepted word to the shadow directory and returns the result it must give.
  function automatic dir_result_t apply_word(input logic [OP_W-1:0] op,
                                             input logic [TAG_W-1:0] tag,
                                             input logic [TIME_W-1:0] now,
                                             input logic [SIDX_W-1:0] sidx);
    dir_result_t r;
    logic        done;
    int          pick;
    longint      least;
    longint      score;
    r = '0;
    done = 1'b0;
    pick = 0;
    least = 0;
    case (op)
      OP_LOOKUP: begin
        for (int i = 0; i < NUM_SLOTS && slot_live[i] && !done; i++) begin
          if (slot_tag[i] == tag) begin
            r.slot  = SIDX_W'(i);
            r.found = 1'b1;
            done    = 1'b1;
            lookup_hits++;
          end
        end
      end
      OP_INSERT: begin
        for (int i = 0; i < NUM_SLOTS && !done; i++) begin
          if (!slot_live[i]) begin
            pick = i;
            done = 1'b1;
          end else if (slot_tag[i] == tag) begin
            pick    = i;
            r.found = 1'b1;
            done    = 1'b1;
          end else begin
            score = retention_score(i, now);
            if (score < least) begin
              least = score;
              pick  = i;
            end
          end
        end
        // A full scan without a free or matching slot means a victim was replaced.
        r.evicted = !done;
        if (!done) evictions++;
        slot_live[pick]  = 1'b1;
        slot_tag[pick]   = tag;
        slot_stamp[pick] = now;
        slot_hits[pick]  = '0;
        r.slot = SIDX_W'(pick);
      end
      OP_HIT: begin
        r.slot = sidx;
        if (int'(sidx) < NUM_SLOTS && slot_live[sidx]) begin
          if (slot_hits[sidx] == HITS_MAX) saturated++;
          else slot_hits[sidx] = slot_hits[sidx] + 1'b1;
          slot_stamp[sidx] = now;
          r.found = 1'b1;
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic flag_leftovers();
    if (expected_q.size() != 0)
      report($sformatf("%0d expected results never arrived", expected_q.size()));
  endtask

  always @(posedge clk) begin
    dir_result_t got;
    dir_result_t want;
    if (!rst_n) begin
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      weight_per_hit = HIT_WEIGHT_RST;
      expected_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.slot    = out_mon.slot;
        got.found   = out_mon.found;
        got.evicted = out_mon.evicted;
        if (expected_q.size() == 0) begin
          report($sformatf("result with nothing expected: slot %0d found %0b evicted %0b",
                           got.slot, got.found, got.evicted));
        end else begin
          want = expected_q.pop_front();
          results++;
          if (got.slot !== want.slot)
            report($sformatf("slot %0d, expected %0d", got.slot, want.slot));
          if (got.found !== want.found)
            report($sformatf("found %0b, expected %0b (slot %0d)", got.found, want.found,
                             want.slot));
          if (got.evicted !== want.evicted)
            report($sformatf("evicted %0b, expected %0b (slot %0d)", got.evicted,
                             want.evicted, want.slot));
        end
      end
      if (cfg_we) weight_per_hit = cfg_wdata;
      if (in_mon.valid && in_mon.ready)
        expected_q.push_back(apply_word(in_mon.opcode, in_mon.tag, in_mon.now,
                                        in_mon.slot_index));
    end
    pending_count <= expected_q.size();
  end

endmodule

FILE: tb/tb_weighted_cache_slot_directory.sv
// Top-level testbench for the weighted cache slot directory: stimulus, pacing and verdict.
module tb_weighted_cache_slot_directory;
  import wcsd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIR_SLOTS      = 64;
  localparam int PHASES         = 8;
  localparam int PHASE_WORDS    = 215;
  // A run of record hits on one slot, so its counter climbs well above the others.
  localparam int HIT_RUN_WORDS  = 40;

  // Pacing modes: which side, if any, inserts idle cycles.
  typedef enum int {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_t;

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  logic [HW_W-1:0] cfg_wdata;

  wcsd_in_if  in_ch ();
  wcsd_out_if out_ch ();

  int fails;
  int pending;
  int checked;
  int evictions;
  int lookup_hits;
  int saturated;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int words_sent    = 0;
  int weights_used  = 0;

  // Tags that the random part draws from, so lookups and inserts often meet live slots.
  logic [TAG_W-1:0]  tag_pool [128];
  logic [TIME_W-1:0] clock_s;

  weighted_cache_slot_directory #(.NUM_SLOTS(DIR_SLOTS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_ch.sink),
    .out_chan  (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  wcsd_checker #(.NUM_SLOTS(DIR_SLOTS)) u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fails),
    .pending_count    (pending),
    .result_count     (checked),
    .evict_count      (evictions),
    .lookup_hit_count (lookup_hits),
    .saturated_count  (saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The result side drops ready at random while a stall mode is active. The stall
  // percentage is itself updated with a nonblocking assignment, so this process always
  // sees the value from before the current edge.
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Safety net: the slowest legal run is well under a tenth of this.
  initial begin
    #40ms;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic set_pace(input pace_t pace);
    case (pace)
      PACE_FULL: begin
        send_idle_pct = 0;
        stall_pct    <= 0;
      end
      PACE_SEND_GAPS: begin
        send_idle_pct = 51;
        stall_pct    <= 0;
      end
      PACE_RECV_STALLS: begin
        send_idle_pct = 0;
        stall_pct    <= 51;
      end
      default: begin
        send_idle_pct = 15;
        stall_pct    <= 15;
      end
    endcase
  endtask

  // Presents one word and returns in the time step of the edge that accepted it. Valid
  // stays high on return, so a word that follows at once keeps the channel busy; anything
  // that pauses the sender must lower valid first. The idle gaps are mostly short, but
  // some span a whole scan so that the next word lands on every stage of the block's work.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [TAG_W-1:0] tag,
                           input logic [TIME_W-1:0] now, input logic [SIDX_W-1:0] sidx);
    int gap;
    gap = 0;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
      gap = ($urandom_range(3) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.tag        <= tag;
    in_ch.now        <= now;
    in_ch.slot_index <= sidx;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  // Stops the sender and waits until every predicted result has been taken.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // The register is only written with the block idle. Every word gives a result, and the
  // block is back in the idle state when it offers that result, so once the last one has
  // gone the block is done; the extra wait before the write is only a margin.
  task automatic write_weight(input logic [HW_W-1:0] w);
    drain();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    weights_used++;
  endtask

  // One random word. Most tags come from the pool so that lookups hit and inserts reuse
  // slots; the rest are fresh and force evictions once the directory is full. Time mostly
  // runs forward, with some jumps anywhere in the range and some steps into the past.
  task automatic send_random_word();
    int                r;
    logic [OP_W-1:0]   op;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] now;
    r = $urandom_range(99);
    if (r < 40) op = OP_INSERT;
    else if (r < 75) op = OP_LOOKUP;
    else op = OP_HIT;
    tag = ($urandom_range(3) == 0) ? $urandom : tag_pool[$urandom_range(127)];
    if (op == OP_INSERT && $urandom_range(3) == 0) tag_pool[$urandom_range(127)] = tag;
    clock_s = clock_s + $urandom_range(0, 2000);
    case ($urandom_range(19))
      0:       now = $urandom;
      1:       now = clock_s - $urandom_range(0, 50000);
      default: now = clock_s;
    endcase
    send_word(op, tag, now, SIDX_W'($urandom_range(DIR_SLOTS - 1)));
  endtask

  initial begin
    logic [HW_W-1:0] phase_weight [PHASES];
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_LOOKUP;
    in_ch.tag        = '0;
    in_ch.now        = '0;
    in_ch.slot_index = '0;
    out_ch.ready     = 1'b0;
    clock_s          = 32'd100000;
    foreach (tag_pool[i]) tag_pool[i] = $urandom;
    tag_pool[0] = 32'h0000_0000;
    tag_pool[1] = 32'hFFFF_FFFF;
    phase_weight = '{10'd0, 10'd1023, 10'd1, 10'd10, HW_W'($urandom_range(1023)), 10'd512,
                     10'd1023, HW_W'($urandom_range(1023))};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    set_pace(PACE_FULL);

    // Directed part, under the reset value of hit_weight. On the empty directory a
    // lookup misses and record hits find nothing to update.
    send_word(OP_LOOKUP, 32'h0000_0000, 32'd0, 6'd0);
    send_word(OP_HIT, 32'hFFFF_FFFF, 32'd7, 6'd0);
    send_word(OP_HIT, 32'h0000_0000, 32'hFFFF_FFFF, 6'd63);
    // First inserts land in the first free slots, at the extremes of tag and time.
    send_word(OP_INSERT, 32'h0000_0000, 32'd0, 6'd0);
    send_word(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
    // Inserting a tag that is already present reuses its slot.
    send_word(OP_INSERT, 32'h0000_0000, 32'd5, 6'd0);
    send_word(OP_LOOKUP, 32'hFFFF_FFFF, 32'd0, 6'd0);
    // A lookup of an absent tag stops at the first free slot.
    send_word(OP_LOOKUP, 32'h0001_2345, 32'd0, 6'd0);
    send_word(OP_HIT, 32'h0000_0000, 32'hFFFF_FFFF, 6'd1);
    send_word(OP_HIT, 32'h0000_0000, 32'd0, 6'd0);
    // A record hit beyond the filled slots is refused.
    send_word(OP_HIT, 32'h0000_0000, 32'd9, 6'd2);

    // Back-to-back record hits on slot 0 build up its hit count.
    for (int i = 0; i < HIT_RUN_WORDS; i++)
      send_word(OP_HIT, $urandom, 32'd5000 + i, 6'd0);

    // Fill the rest of the directory with pool tags at rising times.
    for (int i = 2; i < DIR_SLOTS; i++)
      send_word(OP_INSERT, tag_pool[i], 32'd1000 + 7 * i, SIDX_W'(i));

    // Full directory. A lookup of the tag in the last slot needs the whole scan, a record
    // hit goes to the last slot directly, and a missing tag is searched to the end.
    send_word(OP_LOOKUP, tag_pool[DIR_SLOTS - 1], 32'd0, 6'd0);
    send_word(OP_LOOKUP, 32'h5A5A_A5A5, 32'd0, 6'd0);
    send_word(OP_HIT, 32'h0000_0000, 32'd20000, 6'd63);
    // At time zero no slot is old enough to score below zero (every stamp lies in the
    // future), so slot 0 is the victim by default.
    send_word(OP_INSERT, 32'h1357_9BDF, 32'd0, 6'd0);
    // At the far end of time every slot but slot 1 is stale and the lowest score goes.
    send_word(OP_INSERT, 32'h2468_ACE0, 32'hFFFF_FFFF, 6'd0);
    send_word(OP_INSERT, 32'h0F0F_F0F0, 32'h8000_0000, 6'd0);
    send_word(OP_LOOKUP, 32'h0F0F_F0F0, 32'd0, 6'd0);

    // Random part: each phase sets a new hit_weight and pacing mode, and now and then
    // the sender holds back until the block has answered everything.
    for (int p = 0; p < PHASES; p++) begin
      write_weight(phase_weight[p]);
      set_pace(pace_t'(p % 4));
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(39) == 0) drain();
        send_random_word();
      end
    end

    in_ch.valid <= 1'b0;
    for (int guard = 0; guard < 20000; guard++) begin
      @(posedge clk);
      if (pending == 0) break;
    end
    repeat (80) @(posedge clk);
    u_chk.flag_leftovers();

    $display("Sent %0d words over %0d hit_weight settings and four pacing modes,", words_sent,
             weights_used + 1);
    $display("checked %0d results: %0d evictions, %0d lookup hits, %0d hits at the ceiling.",
             checked, evictions, lookup_hits, saturated);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/wcsd_pkg.sv
sv/wcsd_if.sv
sv/wcsd_weight_unit.sv
sv/weighted_cache_slot_directory.sv
tb/wcsd_checker.sv
tb/tb_weighted_cache_slot_directory.sv
